// ----- hw/rtl/adpcm6_block_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// adpcm6 block decoder assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADPCM6_BLOCK_DECODER_MACROS_SVH
`define ADPCM6_BLOCK_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds at every edge
`define ADPCM6_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// condition implies a result in the following cycle
`define ADPCM6_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ADPCM6_ASSERT(label, cond, msg)
`define ADPCM6_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- hw/rtl/adpcm6_pkg.sv -----
// ----------------------------------------------------------------------------
// adpcm6 package
// Shared types, header layout and predictor coefficients of the decoder.
// ----------------------------------------------------------------------------
package adpcm6_pkg;

	// code and header layout
	localparam int CODE_W         = 6;
	localparam int FILTER_W       = 2;
	localparam int SCALE_W        = 7;
	localparam int HDR_LEFT_BIT   = 5;
	localparam int SCALE_LEFT_BIT = 6;
	localparam logic [SCALE_W-1:0] SHIFT_WRAP = 7'd64;

	// step gain 1057/1024 and history fraction
	localparam int GAIN_PROD_W = 17;
	localparam logic signed [GAIN_PROD_W-1:0] STEP_GAIN = 17'sd1057;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_W      = 8;
	localparam int PRED_SHIFT  = 6;
	localparam int PCM_W       = 16;

	// one decode job handed from the byte parser to the decode engine
	typedef struct packed {
		logic [CODE_W-1:0]   code0;
		logic [CODE_W-1:0]   code1;
		logic                has_code;
		logic                two;
		logic                fin;
		logic [FILTER_W-1:0] filt;
		logic [SCALE_W-1:0]  scale;
	} job_t;

	// first tap coefficient in 1/64
	function automatic logic signed [COEF_W-1:0] coef_a(input logic [FILTER_W-1:0] sel);
		logic signed [COEF_W-1:0] c;
		unique case (sel)
			2'd0: c = 8'sd0;
			2'd1: c = 8'sd60;
			2'd2: c = 8'sd115;
			2'd3: c = 8'sd98;
		endcase
		return c;
	endfunction

	// second tap coefficient in 1/64
	function automatic logic signed [COEF_W-1:0] coef_b(input logic [FILTER_W-1:0] sel);
		logic signed [COEF_W-1:0] c;
		unique case (sel)
			2'd0: c = 8'sd0;
			2'd1: c = 8'sd0;
			2'd2: c = -8'sd52;
			2'd3: c = -8'sd55;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/adpcm6_block_decoder.sv -----
// ----------------------------------------------------------------------------
// adpcm6 block decoder
// 6-bit two-tap ADPCM decoder: compressed bytes in, 16-bit PCM samples out.
// ----------------------------------------------------------------------------
// Order: an accepted byte is registered as a job; the shared sample step with its
// history feedback takes its first code into the output register, then the second
// code of a group-end byte. Throughput while the output is not stalled: one code a
// cycle and one byte per cycle, a group-end byte with two codes stalling the next byte.
// Reset (arst_n low, asynchronous): history zero, no filter, no shift, next byte
// is read as a block header, no item pending.
module adpcm6_block_decoder #(
	parameter int BLOCK_DATA_BYTES = 24,
	parameter int HISTORY_BITS     = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              final_byte,
	output logic                              pcm_valid,
	input  logic                              pcm_stall,
	output logic signed [adpcm6_pkg::PCM_W-1:0] pcm_value,
	output logic                              run_end,
	output logic                              stream_end
);
	import adpcm6_pkg::*;

	logic job_valid;
	job_t job;
	logic job_done;

	// byte parsing and job register
	adpcm6_parse #(
		.BLOCK_DATA_BYTES(BLOCK_DATA_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job_valid  (job_valid),
		.job        (job),
		.job_done   (job_done)
	);

	// sample decode and output register
	adpcm6_engine #(
		.HISTORY_BITS(HISTORY_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.job_done   (job_done),
		.pcm_valid  (pcm_valid),
		.pcm_stall  (pcm_stall),
		.pcm_value  (pcm_value),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

endmodule

// ----- hw/rtl/adpcm6_parse.sv -----
// ----------------------------------------------------------------------------
// adpcm6 byte parser
// Splits the byte stream into headers and 6-bit codes and registers one
// decode job per accepted byte that needs work.
// ----------------------------------------------------------------------------
`include "adpcm6_block_decoder_macros.svh"

module adpcm6_parse #(
	parameter int BLOCK_DATA_BYTES = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              job_valid,
	output adpcm6_pkg::job_t  job,
	input  logic              job_done
);
	import adpcm6_pkg::*;

	localparam int FILL_W = $clog2(BLOCK_DATA_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_DATA_BYTES);

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2
	} pos_t;

	logic                job_valid_s1;
	job_t                job_s1;
	logic [FILL_W-1:0]   fill_q, fill_n, fill_p1, fill_p2;
	pos_t                pos_q, pos_n;
	logic [7:0]          held_q, held_n;
	logic [FILTER_W-1:0] filt_q, filt_n;
	logic [SCALE_W-1:0]  scale_q, scale_n, wrap;
	logic                need_job;
	logic                accept;
	job_t                job_n;

	// next parser state and job for the byte on the port
	always_comb begin
		fill_n   = fill_q;
		pos_n    = pos_q;
		held_n   = held_q;
		filt_n   = filt_q;
		scale_n  = scale_q;
		need_job = 1'b0;
		job_n          = '0;
		job_n.filt     = filt_q;
		job_n.scale    = scale_q;
		job_n.fin      = final_byte;
		fill_p1  = fill_q + FILL_W'(1);
		fill_p2  = fill_q + FILL_W'(2);
		wrap     = SHIFT_WRAP - {1'b0, data_byte[CODE_W-1:0]};
		if (fill_q >= FILL_FULL) begin
			// header byte
			filt_n = data_byte[7:6];
			if (data_byte[HDR_LEFT_BIT]) begin
				scale_n = {1'b1, wrap[CODE_W-1:0]};
			end else begin
				scale_n = {2'b00, data_byte[4:0]};
			end
			fill_n   = '0;
			pos_n    = POS_FIRST;
			need_job = final_byte;
		end else begin
			need_job       = 1'b1;
			job_n.has_code = 1'b1;
			held_n         = data_byte;
			unique case (pos_q)
				POS_SECOND: begin
					job_n.code0 = {held_q[1:0], data_byte[7:4]};
					fill_n      = fill_p1;
					pos_n       = POS_THIRD;
				end
				POS_THIRD: begin
					job_n.code0 = {held_q[3:0], data_byte[7:6]};
					job_n.code1 = data_byte[5:0];
					pos_n       = POS_FIRST;
					if (!final_byte && (fill_p1 < FILL_FULL)) begin
						job_n.two = 1'b1;
						fill_n    = fill_p2;
					end else begin
						fill_n    = fill_p1;
					end
				end
				default: begin
					job_n.code0 = data_byte[7:2];
					pos_n       = POS_SECOND;
				end
			endcase
		end
		// end of stream returns the parser to its reset state
		if (final_byte) begin
			fill_n  = FILL_FULL;
			pos_n   = POS_FIRST;
			held_n  = '0;
			filt_n  = '0;
			scale_n = '0;
		end
	end

	assign byte_stall = job_valid_s1 && !job_done;
	assign accept     = byte_valid && !byte_stall;

	// parser state and job register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			job_s1       <= '0;
			fill_q       <= FILL_FULL;
			pos_q        <= POS_FIRST;
			held_q       <= '0;
			filt_q       <= '0;
			scale_q      <= '0;
		end else if (accept) begin
			job_valid_s1 <= need_job;
			job_s1       <= job_n;
			fill_q       <= fill_n;
			pos_q        <= pos_n;
			held_q       <= held_n;
			filt_q       <= filt_n;
			scale_q      <= scale_n;
		end else if (job_done) begin
			job_valid_s1 <= 1'b0;
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

	`ADPCM6_ASSERT(a_fill_range, fill_q <= FILL_FULL, "block fill past block size")
	`ADPCM6_ASSERT_NEXT(a_job_hold, job_valid_s1 && !job_done, job_valid_s1 && $stable(job_s1), "pending job changed before done")
	`ADPCM6_ASSERT(a_two_has_code, !(job_valid_s1 && job_s1.two) || job_s1.has_code, "two-code job without codes")

endmodule

// ----- hw/rtl/adpcm6_step.sv -----
// ----------------------------------------------------------------------------
// adpcm6 sample step
// Scales one code, adds the two-tap prediction, saturates the new history
// value and clips it to a 16-bit sample.
// ----------------------------------------------------------------------------
module adpcm6_step #(
	parameter int HISTORY_BITS = 48
) (
	input  logic [adpcm6_pkg::CODE_W-1:0]   code,
	input  logic [adpcm6_pkg::FILTER_W-1:0] filt,
	input  logic [adpcm6_pkg::SCALE_W-1:0]  scale,
	input  logic signed [HISTORY_BITS-1:0]  hist_recent,
	input  logic signed [HISTORY_BITS-1:0]  hist_older,
	output logic signed [HISTORY_BITS-1:0]  hist_new,
	output logic signed [adpcm6_pkg::PCM_W-1:0] pcm
);
	import adpcm6_pkg::*;

	localparam int H      = HISTORY_BITS;
	localparam int PW     = H + COEF_W;
	localparam int TERM_W = 65;
	localparam int SW     = ((H + 2) > TERM_W ? (H + 2) : TERM_W) + 1;
	localparam logic signed [H-1:0] HIST_MAX  = {1'b0, {(H-1){1'b1}}};
	localparam logic signed [H-1:0] HIST_MIN  = {1'b1, {(H-1){1'b0}}};
	localparam logic signed [H-1:0] PCM_HI_LIM = {{(H-31){1'b0}}, 15'h7FFF, 16'h0000};
	localparam logic signed [H-1:0] PCM_LO_LIM = {{(H-31){1'b1}}, 31'h0};
	localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

	logic signed [CODE_W-1:0]      code_s;
	logic signed [GAIN_PROD_W-1:0] gain;
	logic signed [SW-1:0]          base, term, pred, sum;
	logic signed [PW-1:0]          prod_a, prod_b, pred_sum;
	logic                          in_range;
	logic                          round_up;

	// scaled step: code * 1057 * 2^16, then the block's shift
	always_comb begin
		code_s = code;
		gain   = GAIN_PROD_W'(code_s) * STEP_GAIN;
		base   = SW'(gain) <<< FRAC_BITS;
		if (scale[SCALE_LEFT_BIT]) begin
			term = base <<< scale[CODE_W-1:0];
		end else begin
			term = base >>> scale[CODE_W-1:0];
		end
	end

	// two-tap prediction, floored to the history grid
	always_comb begin
		prod_a   = PW'(hist_recent) * PW'(coef_a(filt));
		prod_b   = PW'(hist_older) * PW'(coef_b(filt));
		pred_sum = prod_a + prod_b;
		pred     = SW'(pred_sum >>> PRED_SHIFT);
	end

	// saturate the new history value
	always_comb begin
		sum      = term + pred;
		in_range = (&sum[SW-1:H-1]) || !(|sum[SW-1:H-1]);
		if (in_range) begin
			hist_new = sum[H-1:0];
		end else if (sum[SW-1]) begin
			hist_new = HIST_MIN;
		end else begin
			hist_new = HIST_MAX;
		end
	end

	// clip and truncate toward zero
	always_comb begin
		round_up = hist_new[H-1] && (|hist_new[FRAC_BITS-1:0]);
		if (hist_new >= PCM_HI_LIM) begin
			pcm = PCM_MAX;
		end else if (hist_new <= PCM_LO_LIM) begin
			pcm = PCM_MIN;
		end else begin
			pcm = hist_new[FRAC_BITS+PCM_W-1:FRAC_BITS] + PCM_W'(round_up);
		end
	end

endmodule

// ----- hw/rtl/adpcm6_engine.sv -----
// ----------------------------------------------------------------------------
// adpcm6 decode engine
// Runs each job's codes through the sample step one per cycle unless the
// output stalls, keeps predictor history, holds the result item for output.
// ----------------------------------------------------------------------------
`include "adpcm6_block_decoder_macros.svh"

module adpcm6_engine #(
	parameter int HISTORY_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  adpcm6_pkg::job_t                  job,
	output logic                              job_done,
	output logic                              pcm_valid,
	input  logic                              pcm_stall,
	output logic signed [adpcm6_pkg::PCM_W-1:0] pcm_value,
	output logic                              run_end,
	output logic                              stream_end
);
	import adpcm6_pkg::*;

	logic                           phase_q;
	logic signed [HISTORY_BITS-1:0] hist_recent_q, hist_older_q, hist_new;
	logic signed [PCM_W-1:0]        pcm;
	logic                           pcm_valid_q;
	logic signed [PCM_W-1:0]        pcm_value_q;
	logic                           run_end_q, stream_end_q;
	logic [CODE_W-1:0]              cur_code;
	logic                           out_free, do_step, last, emit;

	assign cur_code = phase_q ? job.code1 : job.code0;

	adpcm6_step #(
		.HISTORY_BITS(HISTORY_BITS)
	) u_step (
		.code        (cur_code),
		.filt        (job.filt),
		.scale       (job.scale),
		.hist_recent (hist_recent_q),
		.hist_older  (hist_older_q),
		.hist_new    (hist_new),
		.pcm         (pcm)
	);

	// step control: a clear-only job needs no output slot
	assign out_free = !pcm_valid_q || !pcm_stall;
	assign do_step  = job_valid && (!job.has_code || out_free);
	assign last     = !job.two || phase_q;
	assign job_done = do_step && last;
	assign emit     = do_step && job.has_code;

	// code phase and predictor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= 1'b0;
			hist_recent_q <= '0;
			hist_older_q  <= '0;
		end else begin
			if (job_done) begin
				phase_q <= 1'b0;
			end else if (do_step) begin
				phase_q <= 1'b1;
			end
			if (job_done && job.fin) begin
				hist_recent_q <= '0;
				hist_older_q  <= '0;
			end else if (emit) begin
				hist_recent_q <= hist_new;
				hist_older_q  <= hist_recent_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcm_valid_q <= 1'b0;
		end else if (emit) begin
			pcm_valid_q <= 1'b1;
		end else if (!pcm_stall) begin
			pcm_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pcm_value_q  <= pcm;
			run_end_q    <= last;
			stream_end_q <= last && job.fin;
		end
	end

	assign pcm_valid  = pcm_valid_q;
	assign pcm_value  = pcm_value_q;
	assign run_end    = run_end_q;
	assign stream_end = stream_end_q;

	`ADPCM6_ASSERT(a_phase_two, !phase_q || (job_valid && job.two), "second phase without two-code job")
	`ADPCM6_ASSERT_NEXT(a_hist_clear, job_done && job.fin, (hist_recent_q == '0) && (hist_older_q == '0), "history not cleared at end of stream")
	`ADPCM6_ASSERT_NEXT(a_stream_end_last, emit && job.fin && last, stream_end_q && run_end_q, "stream end not flagged on last sample")

endmodule
